@@ rtl/core/bme_pkg.sv @@
package bme_pkg;

  localparam int unsigned KeyBitsDefault = 32;

  localparam logic RegModulus  = 1'b0;
  localparam logic RegExponent = 1'b1;

endpackage

@@ rtl/core/bme_cell.sv @@
module bme_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic a_i,
  input  logic b_i,
  input  logic carry_i,
  input  logic add_i,
  input  logic acc_i,
  output logic acc_o,
  output logic sum_o,
  output logic carry_o
);

  logic acc_q;
  logic s;
  logic c;

  assign s = b_i ^ (a_i & add_i) ^ carry_i;
  assign c = (b_i & (a_i & add_i)) | (b_i & carry_i) | ((a_i & add_i) & carry_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else begin
      acc_q <= acc_i;
    end
  end

  assign acc_o   = acc_q;
  assign sum_o   = s;
  assign carry_o = c;

endmodule

@@ rtl/core/bme_modmul.sv @@
module bme_modmul #(
  parameter int unsigned KeyBits = bme_pkg::KeyBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [KeyBits-1:0] a_i,
  input  logic [KeyBits-1:0] b_i,
  input  logic [KeyBits-1:0] m_i,
  output logic               done_o,
  output logic [KeyBits-1:0] p_o
);

  localparam int unsigned CntW = $clog2(KeyBits + 1);

  logic [KeyBits-1:0] a_q, a_d;
  logic [KeyBits:0]   acc_q, acc_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [KeyBits+1:0] dbl;
  logic [KeyBits+1:0] r1;
  logic [KeyBits+1:0] r2;
  logic [KeyBits:0]   cell_a;
  logic [KeyBits:0]   cell_sum;
  logic [KeyBits+1:0] cell_c;
  logic [KeyBits+1:0] sum_full;
  logic [KeyBits+1:0] mm;

  assign mm  = {2'b0, m_i};
  assign dbl = {acc_q, 1'b0};
  assign r1  = (dbl >= mm) ? dbl - mm : dbl;
  assign cell_a = {1'b0, b_i};
  assign cell_c[0] = 1'b0;

  genvar g;
  for (g = 0; g <= KeyBits; g++) begin : g_cell
    bme_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .a_i     (cell_a[g]),
      .b_i     (r1[g]),
      .carry_i (cell_c[g]),
      .add_i   (a_q[KeyBits-1]),
      .acc_i   (acc_d[g]),
      .acc_o   (acc_q[g]),
      .sum_o   (cell_sum[g]),
      .carry_o (cell_c[g+1])
    );
  end

  assign sum_full = {cell_c[KeyBits+1] ^ r1[KeyBits+1], cell_sum};
  assign r2 = (sum_full >= mm) ? sum_full - mm : sum_full;

  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d    = a_i;
      acc_d  = '0;
      cnt_d  = CntW'(KeyBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = r2[KeyBits:0];
      a_d   = {a_q[KeyBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign p_o    = r2[KeyBits-1:0];

endmodule

@@ rtl/core/byte_modular_exponentiation.sv @@
// Computes plain_byte ** exponent mod modulus with right-to-left square-and-multiply.
// One shared bit-serial modular multiplier (a chain of KeyBits+1 adder cells)
// forms every product. The byte is first reduced by one product with 1, then
// each exponent bit up to the highest set bit costs one or two products.
// Zero modulus answers 0 with bad_modulus set; zero exponent answers 1.
module byte_modular_exponentiation #(
  parameter int unsigned KeyBits = bme_pkg::KeyBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   plain_byte_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [31:0]  cipher_word_o,
  output logic         bad_modulus_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StWMul = 3'd2;
  localparam logic [2:0] StSq   = 3'd3;
  localparam logic [2:0] StWSq  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StRed  = 3'd6;
  localparam logic [2:0] StWRed = 3'd7;

  logic [2:0]         st_q, st_d;
  logic [KeyBits-1:0] mod_q, exp_q, e_q, e_d, acc_q, acc_d, sq_q, sq_d;
  logic [31:0]        word_q, word_d;
  logic               bad_q, bad_d;
  logic               mul_start;
  logic               mul_done;
  logic [KeyBits-1:0] mul_a, mul_b, mul_p;
  logic [KeyBits-1:0] base_ext;
  logic [31:0]        cfg_v;

  assign cfg_v    = cfg_data_i;
  assign base_ext = KeyBits'({24'b0, plain_byte_i});
  assign cfg_ready_o = (st_q == StIdle);
  assign in_ready_o  = (st_q == StIdle) && !cfg_valid_i;
  assign out_valid_o = (st_q == StOut);
  assign cipher_word_o = word_q;
  assign bad_modulus_o = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= KeyBits'(1);
      exp_q <= KeyBits'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bme_pkg::RegModulus:  mod_q <= KeyBits'(cfg_v);
        bme_pkg::RegExponent: exp_q <= KeyBits'(cfg_v);
        default: ;
      endcase
    end
  end

  bme_modmul #(.KeyBits(KeyBits)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mod_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_comb begin
    st_d = st_q;
    e_d = e_q;
    acc_d = acc_q;
    sq_d = sq_q;
    word_d = word_q;
    bad_d = bad_q;
    mul_start = 1'b0;
    mul_a = acc_q;
    mul_b = sq_q;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          bad_d = 1'b0;
          if (mod_q == '0) begin
            word_d = '0;
            bad_d  = 1'b1;
            st_d   = StOut;
          end else if (exp_q == '0) begin
            word_d = 32'd1;
            st_d   = StOut;
          end else begin
            e_d   = exp_q;
            acc_d = (mod_q == KeyBits'(1)) ? '0 : KeyBits'(1);
            sq_d  = base_ext;
            st_d  = StRed;
          end
        end
      end
      StRed: begin
        mul_start = 1'b1;
        mul_a = sq_q;
        mul_b = acc_q;
        st_d  = StWRed;
      end
      StWRed: begin
        mul_a = sq_q;
        mul_b = acc_q;
        if (mul_done) begin
          sq_d = mul_p;
          st_d = StMul;
        end
      end
      StMul: begin
        if (e_q[0]) begin
          mul_start = 1'b1;
          st_d = StWMul;
        end else begin
          st_d = StSq;
        end
      end
      StWMul: begin
        if (mul_done) begin
          acc_d = mul_p;
          st_d  = StSq;
        end
      end
      StSq: begin
        e_d = e_q >> 1;
        if (e_q[KeyBits-1:1] == '0) begin
          word_d = 32'(acc_q);
          st_d   = StOut;
        end else begin
          mul_start = 1'b1;
          mul_a = sq_q;
          st_d  = StWSq;
        end
      end
      StWSq: begin
        mul_a = sq_q;
        if (mul_done) begin
          sq_d = mul_p;
          st_d = StMul;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    acc_q  <= acc_d;
    sq_q   <= sq_d;
    word_q <= word_d;
    bad_q  <= bad_d;
  end

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_modulus_o |-> cipher_word_o == 32'd0)
    else $error("bad modulus with nonzero word");
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cipher_word_o))
    else $error("result dropped");
  a_no_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

endmodule
